// File: hdl/sm3_pkg.sv
// sm3_pkg: shared types, constants and rotate/permutation functions for the sm3 hash engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sm3_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    BYTE_ZERO,
    BYTE_MARK,
    BYTE_LEN
  } pad_sel_e;

  typedef struct packed {
    logic       absorb;     // write data byte at fill level
    logic       pad_wr;     // write one padding byte at pad pointer
    pad_sel_e   pad_sel;
    logic       pad_start;  // load pad pointer from fill level
    logic       comp_start; // load working regs and message window
    logic       comp_step;  // one round
    logic       comp_done;  // fold working regs into chaining value
    logic       emit_shift; // rotate chaining value for output
    logic       reinit;     // return to initial state
  } ctrl_t;

  typedef struct packed {
    logic       block_full; // absorb filled the buffer
    logic       pad_end;    // pad pointer at last byte
    logic       pad_extra;  // padding needs a second block
    logic       pad_len;    // pad pointer in the length field
    logic       round_last;
  } stat_t;

  localparam logic [31:0] IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };
  localparam logic [31:0] TC_LO = 32'h79CC4519;
  localparam logic [31:0] TC_HI = 32'h7A879D8A;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

// File: hdl/sm3_datapath.sv
// sm3_datapath: block buffer, padding, round datapath and chaining value
// depends on sm3_pkg
`timescale 1ns / 1ps
`default_nettype none
module sm3_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sm3_pkg::ctrl_t ctrl_i,
  input  wire logic [7:0]     data_byte_i,
  output sm3_pkg::stat_t      stat_o,
  output logic [31:0]         digest_word_o
);

  logic [31:0] blk_q [16]; // block buffer as sixteen big-endian words
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [5:0]  pptr_q, pptr_d;
  logic        pblk_q, pblk_d; // 1 while writing the extra first pad block
  logic [31:0] cv_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q, rnd_d;
  logic [7:0]  pad_byte;
  logic [5:0]  wr_idx;
  logic [7:0]  wr_byte;

  // padding byte select
  always_comb begin
    pad_byte = 8'h00;
    unique case (ctrl_i.pad_sel)
      sm3_pkg::BYTE_MARK: pad_byte = sm3_pkg::PAD_MARK;
      sm3_pkg::BYTE_LEN:  pad_byte = bits_q[8*(7-pptr_q[2:0]) +: 8];
      default:            pad_byte = 8'h00;
    endcase
  end

  always_comb begin
    wr_idx  = ctrl_i.absorb ? fill_q : pptr_q;
    wr_byte = ctrl_i.absorb ? data_byte_i : pad_byte;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.absorb || ctrl_i.pad_wr)
      blk_q[wr_idx[5:2]][{~wr_idx[1:0], 3'b000} +: 8] <= wr_byte;
  end

  always_comb begin
    fill_d = fill_q;
    bits_d = bits_q;
    pptr_d = pptr_q;
    pblk_d = pblk_q;
    if (ctrl_i.absorb) begin
      fill_d = fill_q + 6'd1;
      bits_d = bits_q + 64'd8;
    end
    if (ctrl_i.pad_start) begin
      pptr_d = fill_q;
      pblk_d = (fill_q > 6'd55);
    end else if (ctrl_i.pad_wr) begin
      pptr_d = pptr_q + 6'd1;
      if (pptr_q == 6'd63) pblk_d = 1'b0;
    end
    if (ctrl_i.reinit) begin
      fill_d = '0;
      bits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bits_q <= '0;
      pptr_q <= '0;
      pblk_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      fill_q <= fill_d;
      bits_q <= bits_d;
      pptr_q <= pptr_d;
      pblk_q <= pblk_d;
      rnd_q  <= rnd_d;
    end
  end

  always_comb begin
    stat_o.block_full = ctrl_i.absorb && (fill_q == 6'd63);
    stat_o.pad_end    = (pptr_q == 6'd63);
    stat_o.pad_extra  = pblk_q;
    stat_o.pad_len    = (pptr_q[5:3] == 3'b111);
    stat_o.round_last = (rnd_q == 6'd63);
  end

  // round logic
  logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, tc, wn, wj, wpj;
  always_comb begin
    tc  = rnd_q[5:4] == 2'd0 ? sm3_pkg::TC_LO : sm3_pkg::TC_HI;
    a12 = sm3_pkg::rotl(v_q[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + v_q[4] + sm3_pkg::rotl(tc, rnd_q[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_q[5:4] == 2'd0) begin
      ffv = v_q[0] ^ v_q[1] ^ v_q[2];
      ggv = v_q[4] ^ v_q[5] ^ v_q[6];
    end else begin
      ffv = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
      ggv = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
    end
    wj  = w_q[0];
    wpj = w_q[0] ^ w_q[4];
    tt1 = ffv + v_q[3] + ss2 + wpj;
    tt2 = ggv + v_q[7] + ss1 + wj;
    wn  = sm3_pkg::p1(w_q[0] ^ w_q[7] ^ sm3_pkg::rotl(w_q[13], 5'd15))
          ^ sm3_pkg::rotl(w_q[3], 5'd7) ^ w_q[10];
  end

  always_comb begin
    rnd_d = rnd_q;
    if (ctrl_i.comp_start) rnd_d = '0;
    else if (ctrl_i.comp_step) rnd_d = rnd_q + 6'd1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.comp_start) begin
      for (int i = 0; i < 16; i++) w_q[i] <= blk_q[i];
      for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
    end else if (ctrl_i.comp_step) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      v_q[0] <= tt1;
      v_q[1] <= v_q[0];
      v_q[2] <= sm3_pkg::rotl(v_q[1], 5'd9);
      v_q[3] <= v_q[2];
      v_q[4] <= sm3_pkg::p0(tt2);
      v_q[5] <= v_q[4];
      v_q[6] <= sm3_pkg::rotl(v_q[5], 5'd19);
      v_q[7] <= v_q[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) cv_q[i] <= sm3_pkg::IV[i];
    end else if (ctrl_i.reinit) begin
      for (int i = 0; i < 8; i++) cv_q[i] <= sm3_pkg::IV[i];
    end else if (ctrl_i.comp_done) begin
      for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ v_q[i];
    end else if (ctrl_i.emit_shift) begin
      for (int i = 0; i < 7; i++) cv_q[i] <= cv_q[i+1];
      cv_q[7] <= cv_q[0];
    end
  end

  assign digest_word_o = cv_q[0];

endmodule
`default_nettype wire

// File: hdl/sm3_ctrl.sv
// sm3_ctrl: controller state machine for the sm3 hash engine
// depends on sm3_pkg
`timescale 1ns / 1ps
`default_nettype none
module sm3_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           op_i,
  input  wire logic           out_stall_i,
  input  wire sm3_pkg::stat_t stat_i,
  output sm3_pkg::ctrl_t      ctrl_o,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output logic                word_last_o
);

  sm3_pkg::state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       fin_q, fin_d;   // compression is the last block of a finish request
  logic       more_q, more_d; // another pad block follows this compression
  logic       mark_q, mark_d; // 0x80 byte still to write
  logic       in_acc, out_acc;

  assign in_stall_o  = (state_q != sm3_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == sm3_pkg::ST_EMIT);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign word_last_o = (cnt_q == 3'd7);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    more_d  = more_q;
    mark_d  = mark_q;
    unique case (state_q)
      sm3_pkg::ST_IDLE: begin
        if (in_acc && op_i) begin
          state_d = sm3_pkg::ST_PAD;
          mark_d  = 1'b1;
        end else if (in_acc && stat_i.block_full) begin
          state_d = sm3_pkg::ST_COMP;
          fin_d   = 1'b0;
          more_d  = 1'b0;
        end
      end
      sm3_pkg::ST_PAD: begin
        mark_d = 1'b0;
        if (stat_i.pad_end) begin
          state_d = sm3_pkg::ST_COMP;
          fin_d   = !stat_i.pad_extra;
          more_d  = stat_i.pad_extra;
        end
      end
      sm3_pkg::ST_COMP: begin
        // load, 64 rounds, then fold into the chaining value
        if (cnt_q == 3'd0) begin
          cnt_d = 3'd1;
        end else if (cnt_q == 3'd1) begin
          if (stat_i.round_last) cnt_d = 3'd2;
        end else begin
          cnt_d = '0;
          if (fin_q) state_d = sm3_pkg::ST_EMIT;
          else if (more_q) state_d = sm3_pkg::ST_PAD;
          else state_d = sm3_pkg::ST_IDLE;
        end
      end
      sm3_pkg::ST_EMIT: begin
        if (out_acc) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd7) state_d = sm3_pkg::ST_IDLE;
        end
      end
      default: state_d = sm3_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.pad_sel = sm3_pkg::BYTE_ZERO;
    unique case (state_q)
      sm3_pkg::ST_IDLE: begin
        ctrl_o.absorb    = in_acc && !op_i;
        ctrl_o.pad_start = in_acc && op_i;
      end
      sm3_pkg::ST_PAD: begin
        ctrl_o.pad_wr = 1'b1;
        if (mark_q) ctrl_o.pad_sel = sm3_pkg::BYTE_MARK;
        else if (!stat_i.pad_extra && stat_i.pad_len) ctrl_o.pad_sel = sm3_pkg::BYTE_LEN;
      end
      sm3_pkg::ST_COMP: begin
        ctrl_o.comp_start = (cnt_q == 3'd0);
        ctrl_o.comp_step  = (cnt_q == 3'd1);
        ctrl_o.comp_done  = (cnt_q == 3'd2);
      end
      sm3_pkg::ST_EMIT: begin
        ctrl_o.emit_shift = out_acc;
        ctrl_o.reinit     = out_acc && cnt_q == 3'd7;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sm3_pkg::ST_IDLE;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      more_q  <= 1'b0;
      mark_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      more_q  <= more_d;
      mark_q  <= mark_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/sm3_hash_engine.sv
// sm3_hash_engine: top level of the sm3 hash engine
// depends on sm3_pkg, sm3_ctrl, sm3_datapath
// absorb: an absorb that fills the block stalls input during compression (load, 64 rounds, fold)
// finish: pads the block (and one more when fill >= 56), compresses each, then emits 8 words
// throughput: one round per cycle in the shared round unit; input stalls during compression
// reset: asynchronous active low, chaining value to the initial value, counts cleared
`timescale 1ns / 1ps
`default_nettype none
module sm3_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_word_o,
  output logic             word_last_o
);

  sm3_pkg::ctrl_t ctrl;
  sm3_pkg::stat_t stat;

  sm3_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .op_i, .out_stall_i,
    .stat_i(stat), .ctrl_o(ctrl), .in_stall_o, .out_valid_o, .word_last_o
  );

  sm3_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .data_byte_i, .stat_o(stat), .digest_word_o
  );

endmodule
`default_nettype wire
